FILE: hdl/lcpd_pkg.sv
// Shared types, constants and the CRC-16/CCITT byte update for the packet deframer.
// No dependencies; used by lcpd_in_stage, lcpd_core and lrc_crc_packet_deframer_top.
package lcpd_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned CrcW       = 16;
    localparam int unsigned HdrBytes   = 5;
    localparam int unsigned FillW      = 3;
    localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
    localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
    localparam logic [FillW-1:0] FillFull = FillW'(HdrBytes);
    localparam logic [FillW-1:0] FillSlid = FillW'(HdrBytes - 1);

    // item held in the input register
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
    } t_in_stage;

    // status of the framing state, for checks at the top level
    typedef struct packed {
        logic             in_payload;
        logic [FillW-1:0] fill;
    } t_core_status;

    // one byte of crc-16/ccitt, msb first, eight shift steps
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CrcW-1]) begin
                c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[CrcW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/lcpd_in_stage.sv
// Input register stage of the packet deframer: holds one received byte.
// Depends on lcpd_pkg.
module lcpd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_take,
    output lcpd_pkg::t_in_stage o_stage
);
    import lcpd_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_data;
    logic             accept;

    // register is free when empty or when its item moves on this cycle
    assign o_in_ready = !r_valid || i_take;
    assign accept     = i_in_valid && o_in_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

FILE: hdl/lcpd_core.sv
// Framing state, header check, payload crc and result register of the deframer.
// Depends on lcpd_pkg.
module lcpd_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lcpd_pkg::t_in_stage    i_stage,
    output logic                   o_take,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_pkt_id,
    output logic [7:0]             o_payload_byte,
    output logic [7:0]             o_byte_index,
    output logic                   o_last,
    output logic                   o_crc_ok,
    output lcpd_pkg::t_core_status o_status
);
    import lcpd_pkg::*;

    logic [5*ByteW-1:0] r_window, n_window;
    logic [FillW-1:0]   r_fill, n_fill;
    logic               r_in_payload, n_in_payload;
    logic [ByteW-1:0]   r_bytes_left, n_bytes_left;
    logic [CrcW-1:0]    r_crc, n_crc;
    logic [CrcW-1:0]    r_expected, n_expected;
    logic [ByteW-1:0]   r_id, n_id;
    logic [ByteW-1:0]   r_pos, n_pos;

    logic               r_out_valid;
    logic [ByteW-1:0]   r_out_id, r_out_byte, r_out_index;
    logic               r_out_last, r_out_crc_ok;

    logic               out_free;
    logic               is_last;
    logic [CrcW-1:0]    crc_next;
    logic [5*ByteW-1:0] shifted;
    logic [FillW-1:0]   fill_inc;
    logic [ByteW-1:0]   hdr_id, hdr_len, hdr_lo, hdr_hi, hdr_lrc, lrc_sum;
    logic               hdr_ok;

    // header bytes always move on; payload bytes wait for a free result slot
    assign out_free = !r_out_valid || i_out_ready;
    assign o_take   = i_stage.valid && (!r_in_payload || out_free);

    // payload byte work
    assign is_last  = (r_bytes_left <= 8'd1);
    assign crc_next = crc_byte(r_crc, i_stage.data);

    // header window and lrc check: all five bytes sum to zero mod 256 and the length is nonzero
    assign shifted  = {r_window[4*ByteW-1:0], i_stage.data};
    assign fill_inc = (r_fill < FillFull) ? r_fill + 3'd1 : r_fill;
    assign hdr_lrc  = shifted[39:32];
    assign hdr_id   = shifted[31:24];
    assign hdr_len  = shifted[23:16];
    assign hdr_lo   = shifted[15:8];
    assign hdr_hi   = shifted[7:0];
    assign lrc_sum  = hdr_lrc + hdr_id + hdr_len + hdr_lo + hdr_hi;
    assign hdr_ok   = (lrc_sum == 8'd0) && (hdr_len != 8'd0);

    // next framing state
    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_expected   = r_expected;
        n_id         = r_id;
        n_pos        = r_pos;
        if (o_take) begin
            if (r_in_payload) begin
                if (is_last) begin
                    // packet done, restart the hunt
                    n_window     = '0;
                    n_fill       = '0;
                    n_in_payload = 1'b0;
                    n_bytes_left = '0;
                    n_crc        = CrcInit;
                    n_pos        = '0;
                end else begin
                    n_crc        = crc_next;
                    n_bytes_left = r_bytes_left - 8'd1;
                    n_pos        = r_pos + 8'd1;
                end
            end else begin
                n_window = shifted;
                n_fill   = fill_inc;
                if (fill_inc >= FillFull) begin
                    if (hdr_ok) begin
                        n_in_payload = 1'b1;
                        n_id         = hdr_id;
                        n_bytes_left = hdr_len;
                        n_pos        = '0;
                        n_expected   = {hdr_hi, hdr_lo};
                        n_crc        = CrcInit;
                    end else begin
                        // slide by one byte
                        n_fill = FillSlid;
                    end
                end
            end
        end
    end

    // framing state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
            r_crc        <= CrcInit;
            r_expected   <= '0;
            r_id         <= '0;
            r_pos        <= '0;
        end else begin
            r_window     <= n_window;
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_expected   <= n_expected;
            r_id         <= n_id;
            r_pos        <= n_pos;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && r_in_payload) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take && r_in_payload) begin
            r_out_id     <= r_id;
            r_out_byte   <= i_stage.data;
            r_out_index  <= r_pos;
            r_out_last   <= is_last;
            r_out_crc_ok <= is_last && (crc_next == r_expected);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pkt_id       = r_out_id;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_index;
    assign o_last         = r_out_last;
    assign o_crc_ok       = r_out_crc_ok;

    assign o_status.in_payload = r_in_payload;
    assign o_status.fill       = r_fill;

endmodule

FILE: hdl/lrc_crc_packet_deframer_top.sv
// Packet deframer: hunts for an lrc-checked five-byte header, then streams the payload
// with a crc-16/ccitt check. A payload byte passes the input register, then the output
// result register. Throughput: one byte per cycle while the output is not stalled.
// Header bytes produce no item; they advance even while the output is stalled.
// Reset (synchronous, active low) empties both registers and restarts the hunt.
// Depends on lcpd_pkg, lcpd_in_stage and lcpd_core.
module lrc_crc_packet_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pkt_id,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_byte_index,
    output logic       o_last,
    output logic       o_crc_ok
);
    import lcpd_pkg::*;

    t_in_stage    stage;
    t_core_status status;
    logic         take;

    // input register
    lcpd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_stage    (stage)
    );

    // framing logic and result register
    lcpd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (stage),
        .o_take         (take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pkt_id       (o_pkt_id),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last),
        .o_crc_ok       (o_crc_ok),
        .o_status       (status)
    );

    // crc pass is reported only on the last byte
    a_crc_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crc_ok) |-> o_last)
        else $error("crc_ok set on a byte that is not last");

    // header fill never goes past five bytes
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill <= FillFull)
        else $error("header fill out of range");

    // the header window stays full through the payload
    a_payload_fill_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.in_payload |-> (status.fill == FillFull))
        else $error("header fill not full during payload");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
